// File: hw/rtl/lpg_pkg.sv
// shared types and constants for the line pixel generator
package lpg_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned DeltaW = 17;
    localparam int unsigned ErrW   = 18;

    // item kind codes
    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } t_kind;

    // classified word passed from the front to the back
    typedef struct packed {
        t_kind                     kind;
        logic signed [CoordW-1:0]  x_start;
        logic signed [CoordW-1:0]  y_start;
        logic signed [CoordW-1:0]  x_end;
        logic signed [CoordW-1:0]  y_end;
        logic        [DeltaW-1:0]  abs_dx;
        logic signed [DeltaW-1:0]  neg_abs_dy;
        logic signed [ErrW-1:0]    error_init;
        logic                      dir_x_neg;
        logic                      dir_y_neg;
    } t_cmd;

endpackage

// File: hw/rtl/lpg_front.sv
// front end: accepts input words and precomputes line deltas on a load
module lpg_front (
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic signed [lpg_pkg::CoordW-1:0]   i_x_start,
    input  logic signed [lpg_pkg::CoordW-1:0]   i_y_start,
    input  logic signed [lpg_pkg::CoordW-1:0]   i_x_end,
    input  logic signed [lpg_pkg::CoordW-1:0]   i_y_end,
    input  logic                                i_q_full,
    output logic                                o_push,
    output lpg_pkg::t_cmd                       o_cmd
);
    import lpg_pkg::*;

    logic signed [DeltaW-1:0] ddx;
    logic signed [DeltaW-1:0] ddy;
    logic        [DeltaW-1:0] abs_dx;
    logic signed [DeltaW-1:0] neg_abs_dy;

    // handshake toward the sender
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // signed differences, one extra bit so they never overflow
    assign ddx = DeltaW'(signed'({i_x_end[CoordW-1], i_x_end}))
               - DeltaW'(signed'({i_x_start[CoordW-1], i_x_start}));
    assign ddy = DeltaW'(signed'({i_y_end[CoordW-1], i_y_end}))
               - DeltaW'(signed'({i_y_start[CoordW-1], i_y_start}));

    // magnitudes
    assign abs_dx     = ddx[DeltaW-1] ? DeltaW'(-ddx) : DeltaW'(ddx);
    assign neg_abs_dy = ddy[DeltaW-1] ? ddy : -ddy;

    // classified word
    always_comb begin
        o_cmd.kind       = t_kind'(i_kind);
        o_cmd.x_start    = i_x_start;
        o_cmd.y_start    = i_y_start;
        o_cmd.x_end      = i_x_end;
        o_cmd.y_end      = i_y_end;
        o_cmd.abs_dx     = abs_dx;
        o_cmd.neg_abs_dy = neg_abs_dy;
        o_cmd.error_init = ErrW'(signed'({1'b0, abs_dx}))
                         + ErrW'(signed'({neg_abs_dy[DeltaW-1], neg_abs_dy}));
        // step toward smaller values unless start is strictly below end
        o_cmd.dir_x_neg  = (ddx <= 0);
        o_cmd.dir_y_neg  = (ddy <= 0);
    end

endmodule

// File: hw/rtl/lpg_queue.sv
// short command queue between the front and the back
module lpg_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpg_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output lpg_pkg::t_cmd o_cmd
);
    import lpg_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_cmd            r_slot [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/lpg_back.sv
// back end: line state, pixel stepping and the output register
module lpg_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  lpg_pkg::t_cmd                       i_cmd,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lpg_pkg::CoordW-1:0]   o_pixel_x,
    output logic signed [lpg_pkg::CoordW-1:0]   o_pixel_y,
    output logic                                o_last
);
    import lpg_pkg::*;

    localparam int unsigned E2W = ErrW + 1;

    logic signed [CoordW-1:0] r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic        [DeltaW-1:0] r_abs_dx;
    logic signed [DeltaW-1:0] r_neg_abs_dy;
    logic signed [ErrW-1:0]   r_error;
    logic                     r_dir_x_neg, r_dir_y_neg;
    logic                     r_busy;
    logic                     r_out_valid;
    logic signed [CoordW-1:0] r_pixel_x, r_pixel_y;
    logic                     r_last;

    logic                     out_free;
    logic                     is_load;
    logic                     emit;
    logic                     at_end;
    logic signed [E2W-1:0]    e2;
    logic signed [E2W-1:0]    ndy_ext;
    logic signed [E2W-1:0]    dx_ext;
    logic                     move_x, move_y;
    logic signed [E2W-1:0]    err_sum;

    // pop decision: loads and idle steps never wait on the output
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_load  = (i_cmd.kind == KIND_LOAD);
    assign o_pop    = i_q_valid && (is_load || !r_busy || out_free);
    assign emit     = i_q_valid && !is_load && r_busy && out_free;

    // bresenham step decision
    assign at_end  = (r_cur_x == r_end_x) && (r_cur_y == r_end_y);
    assign e2      = E2W'(signed'({r_error, 1'b0}));
    assign ndy_ext = E2W'(r_neg_abs_dy);
    assign dx_ext  = E2W'(signed'({1'b0, r_abs_dx}));
    assign move_x  = (e2 >= ndy_ext);
    assign move_y  = (e2 <= dx_ext);
    assign err_sum = E2W'(r_error) + (move_x ? ndy_ext : '0) + (move_y ? dx_ext : '0);

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_end_x      <= '0;
            r_end_y      <= '0;
            r_abs_dx     <= '0;
            r_neg_abs_dy <= '0;
            r_error      <= '0;
            r_dir_x_neg  <= 1'b0;
            r_dir_y_neg  <= 1'b0;
            r_busy       <= 1'b0;
        end else if (o_pop && is_load) begin
            r_cur_x      <= i_cmd.x_start;
            r_cur_y      <= i_cmd.y_start;
            r_end_x      <= i_cmd.x_end;
            r_end_y      <= i_cmd.y_end;
            r_abs_dx     <= i_cmd.abs_dx;
            r_neg_abs_dy <= i_cmd.neg_abs_dy;
            r_error      <= i_cmd.error_init;
            r_dir_x_neg  <= i_cmd.dir_x_neg;
            r_dir_y_neg  <= i_cmd.dir_y_neg;
            r_busy       <= 1'b1;
        end else if (emit) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_error <= ErrW'(err_sum);
                if (move_x) begin
                    r_cur_x <= r_dir_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                end
                if (move_y) begin
                    r_cur_y <= r_dir_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                end
            end
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pixel_x <= r_cur_x;
            r_pixel_y <= r_cur_y;
            r_last    <= at_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_pixel_x;
    assign o_pixel_y   = r_pixel_y;
    assign o_last      = r_last;

    // a step while idle is dropped without producing a word
    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && !is_load && !r_busy && out_free) |=> !r_out_valid)
        else $error("step while idle produced a word");

    // the end pixel finishes the line
    a_last_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && at_end) |=> (!r_busy && r_out_valid && r_last))
        else $error("end pixel did not finish the line");

    // a load is never held back by a stalled output
    a_load_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && is_load) |-> o_pop)
        else $error("load word not taken");

    // a new word is only produced when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

endmodule

// File: hw/rtl/line_pixel_generator_core.sv
// top level of the bresenham line pixel generator
//
// Input channel (i_in_valid / o_in_stall): a word with i_kind = load carries
// the start and end points and gives no output; a word with i_kind = step
// emits the current pixel of the running line. A step with no line running
// is dropped. A load while a line runs abandons it and starts the new one.
// Output channel (o_out_valid / i_out_stall): one word per busy step, with
// o_last set on the end point, after which the line is finished.
// A step passes through the queue and then the output register.
// Throughput: one word per cycle in each direction while neither side stalls;
// every step is one add-and-compare pass of the error term in the back end.
// A QUEUE_DEPTH entry queue sits between the front end, which computes the
// deltas of a load, and the back end, which owns the line state. When the
// receiver stalls, the output register holds its word, steps wait in the
// queue and o_in_stall rises once it is full; loads at the head still drain.
// Reset (synchronous, active low) empties the queue, clears the output
// valid and leaves no line running.
module line_pixel_generator_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic signed [lpg_pkg::CoordW-1:0]   i_x_start,
    input  logic signed [lpg_pkg::CoordW-1:0]   i_y_start,
    input  logic signed [lpg_pkg::CoordW-1:0]   i_x_end,
    input  logic signed [lpg_pkg::CoordW-1:0]   i_y_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lpg_pkg::CoordW-1:0]   o_pixel_x,
    output logic signed [lpg_pkg::CoordW-1:0]   o_pixel_y,
    output logic                                o_last
);
    import lpg_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    // classify incoming words
    lpg_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    // decoupling queue
    lpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (back_cmd)
    );

    // line stepping and output
    lpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last      (o_last)
    );

endmodule
